### design/crcfp_pkg.sv
// ----------------------------------------------------------------------------
// crcfp_pkg
// Shared types, widths and the CRC-16-CCITT byte step for the frame parser.
// ----------------------------------------------------------------------------
package crcfp_pkg;

  localparam int unsigned FILL_W       = 11;
  localparam int unsigned LEN_W        = 10;
  localparam int unsigned PAYLOAD_MAX_D  = 1023;
  localparam int unsigned BUFFER_BYTES_D = 1028;
  localparam int unsigned START_BYTE_D   = 170;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_TRY,
    S_F1,
    S_F2,
    S_CRC,
    S_C1,
    S_C2,
    S_CMD,
    S_COPY,
    S_SCAN
  } state_t;

  // Request from the sequencer to the frame buffer ring
  typedef struct packed {
    logic              we;
    logic [FILL_W-1:0] wr_off;
    logic [7:0]        wdata;
    logic [FILL_W-1:0] rd_off;
  } ring_req_t;

  // One byte through CRC-16-CCITT, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### design/crcfp_ring.sv
// ----------------------------------------------------------------------------
// crcfp_ring
// Circular frame buffer: offsets are taken relative to the head pointer,
// one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module crcfp_ring
  import crcfp_pkg::*;
#(
  parameter int unsigned AW = 11
) (
  input  logic          clk,
  input  logic [AW-1:0] head,
  input  ring_req_t     req,
  output logic [7:0]    rdata
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_r;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // Ring addressing wraps at the power-of-two depth
  assign waddr = head + req.wr_off[AW-1:0];
  assign raddr = head + req.rd_off[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[waddr] <= req.wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/crc16_frame_parser_resync_top.sv
// Sequencing: a read request passes through S_RD; a byte fed into an empty buffer
// is answered from S_IDLE. A byte that extends a frame runs S_TRY, S_F1, S_F2, the CRC
// pass in S_CRC, S_C1 and S_C2, then S_CMD and the copy in S_COPY; a resync scans in S_SCAN.
// Throughput: one request at a time, paced by the single read port of the buffer.
// Reset: synchronous active-low rst_n clears fill count, head, last-frame report
// and control; buffer and data memories are not cleared.
// ----------------------------------------------------------------------------
// crc16_frame_parser_resync_top
// CRC-16-CCITT framed packet parser with resync over a circular byte buffer.
// ----------------------------------------------------------------------------
module crc16_frame_parser_resync_top
  import crcfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_MAX  = PAYLOAD_MAX_D,
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_D,
  parameter int unsigned START_BYTE   = START_BYTE_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [7:0]        in_rx_byte,
  input  logic [LEN_W-1:0]  in_read_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_frame_valid,
  output logic [7:0]        out_command_id,
  output logic              out_write_flag,
  output logic [LEN_W-1:0]  out_data_length,
  output logic [7:0]        out_read_data,
  output logic [FILL_W-1:0] out_buffered_bytes
);

  localparam int unsigned AW    = $clog2(BUFFER_BYTES);
  localparam int unsigned DS_AW = $clog2(PAYLOAD_MAX + 1);
  localparam logic [FILL_W-1:0] BUF_FULL = FILL_W'(BUFFER_BYTES);
  localparam logic [LEN_W-1:0]  PMAX     = LEN_W'(PAYLOAD_MAX);
  localparam logic [7:0]        START    = 8'(START_BYTE);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt;
  logic [7:0]        flo_r, flo_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        crclo_r, crclo_nxt;
  logic [7:0]        last_cmd_r, last_cmd_nxt;
  logic              last_wr_r, last_wr_nxt;
  logic [LEN_W-1:0]  last_len_r, last_len_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_fv_r, out_fv_nxt;
  logic [7:0]        out_rd_r, out_rd_nxt;

  ring_req_t         ring_req;
  logic [7:0]        ring_rdata;
  logic              ds_we;
  logic [DS_AW-1:0]  ds_waddr;
  logic [7:0]        ds_wdata;
  logic [7:0]        ds_rdata_r;
  logic [7:0]        ds_mem [PAYLOAD_MAX];

  logic              accept;
  logic [FILL_W-1:0] fill_eff;
  logic [LEN_W-1:0]  plen_new;
  logic [FILL_W-1:0] total_new;
  logic [FILL_W-1:0] total_r;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign fill_eff  = (fill_r >= BUF_FULL) ? '0 : fill_r;
  assign plen_new  = {ring_rdata, flo_r[7:6]};
  assign total_new = {1'b0, plen_new} + FILL_W'(5);
  assign total_r   = {1'b0, plen_r} + FILL_W'(5);

  // Frame buffer ring
  crcfp_ring #(.AW(AW)) u_ring (
    .clk   (clk),
    .head  (head_r),
    .req   (ring_req),
    .rdata (ring_rdata)
  );

  // Data store memory
  always_ff @(posedge clk) begin
    if (ds_we) begin
      ds_mem[ds_waddr] <= ds_wdata;
    end
    ds_rdata_r <= ds_mem[in_read_index[DS_AW-1:0]];
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    plen_nxt      = plen_r;
    flo_nxt       = flo_r;
    crc_nxt       = crc_r;
    crclo_nxt     = crclo_r;
    last_cmd_nxt  = last_cmd_r;
    last_wr_nxt   = last_wr_r;
    last_len_nxt  = last_len_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r;
    out_fv_nxt    = out_fv_r;
    out_rd_nxt    = out_rd_r;
    ring_req      = '0;
    ds_we         = 1'b0;
    ds_waddr      = cnt_r[DS_AW-1:0];
    ds_wdata      = ring_rdata;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode) begin
            rd_ok_nxt = in_read_index < last_len_r;
            state_nxt = S_RD;
          end else if (fill_eff == '0) begin
            // Empty buffer: only a start byte is kept
            if (in_rx_byte == START) begin
              ring_req.we    = 1'b1;
              ring_req.wdata = in_rx_byte;
              fill_nxt       = FILL_W'(1);
            end else begin
              fill_nxt = '0;
            end
            out_valid_nxt = 1'b1;
            out_fv_nxt    = 1'b0;
            out_rd_nxt    = '0;
          end else begin
            ring_req.we     = 1'b1;
            ring_req.wr_off = fill_eff;
            ring_req.wdata  = in_rx_byte;
            fill_nxt        = fill_eff + FILL_W'(1);
            state_nxt       = S_TRY;
          end
        end
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_fv_nxt    = 1'b0;
        out_rd_nxt    = rd_ok_r ? ds_rdata_r : '0;
        state_nxt     = S_IDLE;
      end
      S_TRY: begin
        if (fill_r < FILL_W'(3)) begin
          out_valid_nxt = 1'b1;
          out_fv_nxt    = 1'b0;
          out_rd_nxt    = '0;
          state_nxt     = S_IDLE;
        end else begin
          ring_req.rd_off = FILL_W'(1);
          state_nxt       = S_F1;
        end
      end
      S_F1: begin
        flo_nxt         = ring_rdata;
        ring_req.rd_off = FILL_W'(2);
        state_nxt       = S_F2;
      end
      S_F2: begin
        plen_nxt = plen_new;
        if (plen_new == '0 || plen_new > PMAX) begin
          // Bad length: rescan past the start byte
          if (fill_r <= FILL_W'(1)) begin
            fill_nxt      = '0;
            out_valid_nxt = 1'b1;
            out_fv_nxt    = 1'b0;
            out_rd_nxt    = '0;
            state_nxt     = S_IDLE;
          end else begin
            ring_req.rd_off = FILL_W'(1);
            cnt_nxt         = FILL_W'(1);
            state_nxt       = S_SCAN;
          end
        end else if (fill_r < total_new) begin
          out_valid_nxt = 1'b1;
          out_fv_nxt    = 1'b0;
          out_rd_nxt    = '0;
          state_nxt     = S_IDLE;
        end else begin
          crc_nxt         = '0;
          cnt_nxt         = '0;
          ring_req.rd_off = '0;
          state_nxt       = S_CRC;
        end
      end
      S_CRC: begin
        // One header or payload byte per cycle
        crc_nxt         = crc_byte(crc_r, ring_rdata);
        cnt_nxt         = cnt_r + FILL_W'(1);
        ring_req.rd_off = cnt_r + FILL_W'(1);
        if (cnt_r == total_r - FILL_W'(3)) begin
          state_nxt = S_C1;
        end
      end
      S_C1: begin
        crclo_nxt       = ring_rdata;
        ring_req.rd_off = total_r - FILL_W'(1);
        state_nxt       = S_C2;
      end
      S_C2: begin
        if ({ring_rdata, crclo_r} == crc_r) begin
          ring_req.rd_off = FILL_W'(3);
          state_nxt       = S_CMD;
        end else if (fill_r <= FILL_W'(1)) begin
          fill_nxt      = '0;
          out_valid_nxt = 1'b1;
          out_fv_nxt    = 1'b0;
          out_rd_nxt    = '0;
          state_nxt     = S_IDLE;
        end else begin
          ring_req.rd_off = FILL_W'(1);
          cnt_nxt         = FILL_W'(1);
          state_nxt       = S_SCAN;
        end
      end
      S_CMD: begin
        last_cmd_nxt    = ring_rdata;
        last_wr_nxt     = flo_r[0];
        last_len_nxt    = plen_r - LEN_W'(1);
        cnt_nxt         = '0;
        ring_req.rd_off = FILL_W'(4);
        if (plen_r == LEN_W'(1)) begin
          head_nxt      = head_r + total_r[AW-1:0];
          fill_nxt      = fill_r - total_r;
          out_valid_nxt = 1'b1;
          out_fv_nxt    = 1'b1;
          out_rd_nxt    = '0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        // Copy data bytes out of the ring, one per cycle
        ds_we           = 1'b1;
        cnt_nxt         = cnt_r + FILL_W'(1);
        ring_req.rd_off = cnt_r + FILL_W'(5);
        if (cnt_r == {1'b0, plen_r} - FILL_W'(2)) begin
          head_nxt      = head_r + total_r[AW-1:0];
          fill_nxt      = fill_r - total_r;
          out_valid_nxt = 1'b1;
          out_fv_nxt    = 1'b1;
          out_rd_nxt    = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        if (ring_rdata == START) begin
          head_nxt  = head_r + cnt_r[AW-1:0];
          fill_nxt  = fill_r - cnt_r;
          state_nxt = S_TRY;
        end else if (cnt_r + FILL_W'(1) >= fill_r) begin
          fill_nxt      = '0;
          out_valid_nxt = 1'b1;
          out_fv_nxt    = 1'b0;
          out_rd_nxt    = '0;
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt         = cnt_r + FILL_W'(1);
          ring_req.rd_off = cnt_r + FILL_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      last_cmd_r  <= '0;
      last_wr_r   <= 1'b0;
      last_len_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      last_cmd_r  <= last_cmd_nxt;
      last_wr_r   <= last_wr_nxt;
      last_len_r  <= last_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    plen_r   <= plen_nxt;
    flo_r    <= flo_nxt;
    crc_r    <= crc_nxt;
    crclo_r  <= crclo_nxt;
    rd_ok_r  <= rd_ok_nxt;
    out_fv_r <= out_fv_nxt;
    out_rd_r <= out_rd_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_frame_valid    = out_fv_r;
  assign out_command_id     = last_cmd_r;
  assign out_write_flag     = last_wr_r;
  assign out_data_length    = last_len_r;
  assign out_read_data      = out_rd_r;
  assign out_buffered_bytes = fill_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= BUF_FULL)
    else $error("fill count above buffer size");

  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !out_valid_r)
    else $error("result pending while sequencer busy");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    last_len_r < PMAX)
    else $error("data length out of range");

  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |=> out_valid_r && !out_fv_r)
    else $error("read request did not complete");
`endif

endmodule
